[hdl/c3bs_pkg.sv]
// Shared types and constants for the 3x3 blur/sharpen filter.
package c3bs_pkg;

    localparam int PIX_OUT_W  = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int MG_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHARPEN_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GRAY     = 2'd3;

    // per-pixel bookkeeping carried down the pipe
    typedef struct packed {
        logic [PIX_OUT_W-1:0] pix;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [COL_W-1:0]     wm1_col;
        logic                 r_ge1;
        logic                 r_ge2;
        logic                 c_is0;
        logic                 c_is1;
        logic                 last_row;
    } meta_t;

    // one result beat
    typedef struct packed {
        logic [PIX_OUT_W-1:0] pixel;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic                 filtered;
        logic                 last;
    } result_t;

endpackage

[hdl/c3bs_ram.sv]
// Generic RAM: one write port, two registered read ports (read-first).
module c3bs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

[hdl/conv3x3_blur_sharpen.sv]
// Top level: streaming 3x3 Gaussian blur / sharpen filter for gray images.
//   Pixels enter in raster order on the s_ channel (valid/ready), one beat
//   per pixel. Results leave on the m_ channel (valid/ready), each carrying
//   its value, row, column, a filtered flag and a last-of-run flag.
//   Registers are written on the cfg_ channel (always ready), by the user
//   only while idle; the block itself does not enforce this. Throughput: one
//   pixel per cycle while m_ready is high; pixels of the last image row give
//   two result beats each, so the m_ channel, which moves one beat per cycle,
//   limits the pixel rate there. Rows above the last give at most one beat
//   per pixel. A result beat reaches the m_ ports through registered steps
//   after the pixel beat that causes it (RAM read on the accepting edge,
//   window update, filter into the output reg). A pixel on the first row
//   gives no beat; the first row comes out while the second row goes in.
//   Stall: when m_ready is low the output register and a pending second
//   result hold; the two internal stages still fill, so up to two more
//   beat-producing pixels are taken before s_ready drops.
//   Reset (aresetn low, synchronous): counters and the window clear, the
//   registers return to 1024x1024, blur, max gray 255. Line buffers are not
//   cleared; stale entries may be read but never reach a result beat within a frame.
module conv3x3_blur_sharpen
    import c3bs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_OUT_W-1:0]  s_pixel_in,
    // results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_OUT_W-1:0]  m_pixel_out,
    output logic [ROW_W-1:0]      m_out_row,
    output logic [COL_W-1:0]      m_out_col,
    output logic                  m_is_filtered,
    output logic                  m_last_in_run
);

    localparam int PB    = PIXEL_BITS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WCW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = (WCW > FW_W) ? WCW : FW_W;
    localparam int SW    = PB + 5;
    localparam int GW    = (SW > MG_W) ? SW : MG_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic            sharpen_mode_reg;
    logic [MG_W-1:0] max_gray_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FW_W'(1024);
            frame_height_reg <= FH_W'(1024);
            sharpen_mode_reg <= 1'b0;
            max_gray_reg     <= MG_W'(255);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                REG_SHARPEN_MODE: sharpen_mode_reg <= cfg_data[0];
                REG_MAX_GRAY:     max_gray_reg     <= cfg_data[MG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective frame size, saturated to the legal range
    logic [CMPW-1:0] fw_ext;
    logic [CMPW-1:0] w_eff;
    logic [CMPW-1:0] w_eff_m1;
    logic [FH_W-1:0] h_eff;
    logic [FH_W-1:0] h_eff_m1;

    always_comb begin
        fw_ext = CMPW'(frame_width_reg);
        if (fw_ext < CMPW'(MIN_SIZE)) begin
            w_eff = CMPW'(MIN_SIZE);
        end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        w_eff_m1 = w_eff - CMPW'(1);

        if (frame_height_reg < FH_W'(MIN_SIZE)) begin
            h_eff = FH_W'(MIN_SIZE);
        end else if (frame_height_reg > FH_W'(MAX_HEIGHT)) begin
            h_eff = FH_W'(MAX_HEIGHT);
        end else begin
            h_eff = frame_height_reg;
        end
        h_eff_m1 = h_eff - FH_W'(1);
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic    s1_valid_reg;
    logic    s2_valid_reg;
    logic    m_valid_reg;
    logic    pend_valid_reg;
    logic    s1_move;
    logic    s2_move;
    logic    out_can;
    logic    s2_none;
    logic    accept;
    meta_t   s2_meta_reg;

    // output reg can take a new pair: empty, or drained this cycle with
    // nothing pending behind it
    assign out_can = !m_valid_reg || (m_ready && !pend_valid_reg);
    assign s2_none = !s2_meta_reg.r_ge1 && !s2_meta_reg.last_row;
    assign s2_move = s2_valid_reg && (s2_none || out_can);
    assign s1_move = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign s_ready = !s1_valid_reg || s1_move;
    assign accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Position counters (advance on each accepted beat)
    // ------------------------------------------------------------------
    logic [CW-1:0]    col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic [CW-1:0]    col_next;
    logic [ROW_W-1:0] row_next;
    logic             last_col;
    logic             last_row;
    logic [CW-1:0]    wm1_addr;
    logic [PB-1:0]    pix_in;

    assign pix_in   = PB'(s_pixel_in);
    assign wm1_addr = CW'(w_eff_m1);
    assign last_col = CMPW'(col_count_reg) >= w_eff_m1;
    assign last_row = FH_W'(row_count_reg) >= h_eff_m1;

    always_comb begin
        col_next = col_count_reg;
        row_next = row_count_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_count_reg + ROW_W'(1);
        end else begin
            col_next = col_count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (accept) begin
            col_count_reg <= col_next;
            row_count_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffers. Middle line: written with the new pixel on accept,
    // read at the current column and at the last column. Upper line:
    // takes the old middle value one stage later.
    // ------------------------------------------------------------------
    logic [CW-1:0] s1_addr_reg;
    logic [PB-1:0] up_rd;
    logic [PB-1:0] mid_rd_a;
    logic [PB-1:0] mid_rd_b;

    c3bs_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .aclk      (aclk),
        .we        (accept),
        .wr_addr   (col_count_reg),
        .wr_data   (pix_in),
        .re        (accept),
        .rd_addr_a (col_count_reg),
        .rd_addr_b (wm1_addr),
        .rd_data_a (mid_rd_a),
        .rd_data_b (mid_rd_b)
    );

    c3bs_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .aclk      (aclk),
        .we        (s1_move),
        .wr_addr   (s1_addr_reg),
        .wr_data   (mid_rd_a),
        .re        (accept),
        .rd_addr_a (col_count_reg),
        .rd_addr_b (col_count_reg),
        .rd_data_a (up_rd),
        .rd_data_b ()
    );

    // ------------------------------------------------------------------
    // Stage 1: pixel and position, aligned with RAM read data
    // ------------------------------------------------------------------
    meta_t         s1_meta_reg;
    logic [PB-1:0] s1_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg          <= col_count_reg;
            s1_pix_reg           <= pix_in;
            s1_meta_reg.pix      <= PIX_OUT_W'(pix_in);
            s1_meta_reg.row      <= row_count_reg;
            s1_meta_reg.col      <= COL_W'(col_count_reg);
            s1_meta_reg.wm1_col  <= COL_W'(wm1_addr);
            s1_meta_reg.r_ge1    <= row_count_reg != '0;
            s1_meta_reg.r_ge2    <= row_count_reg >= ROW_W'(2);
            s1_meta_reg.c_is0    <= col_count_reg == '0;
            s1_meta_reg.c_is1    <= col_count_reg == CW'(1);
            s1_meta_reg.last_row <= last_row;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: 3x3 window shifts in the new column
    // win_reg[0..2] top row, [3..5] middle, [6..8] bottom, right = newest
    // ------------------------------------------------------------------
    logic [PB-1:0] win_reg [0:8];
    logic [PB-1:0] s2_midb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_move) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= up_rd;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= mid_rd_a;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= s1_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_move) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_move) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            s2_meta_reg <= s1_meta_reg;
            s2_midb_reg <= mid_rd_b;
        end
    end

    // ------------------------------------------------------------------
    // Kernel: shifts and adds, then clamp to 0..max_gray
    // ------------------------------------------------------------------
    logic [PB+1:0]        corners;
    logic [PB+1:0]        edges;
    logic [PB+3:0]        blur_sum;
    logic [SW-1:0]        sharp_sum;
    logic [SW-1:0]        filt_val;
    logic [PIX_OUT_W-1:0] filt_pix;

    always_comb begin
        corners   = (PB+2)'(win_reg[0]) + (PB+2)'(win_reg[2])
                  + (PB+2)'(win_reg[6]) + (PB+2)'(win_reg[8]);
        edges     = (PB+2)'(win_reg[1]) + (PB+2)'(win_reg[3])
                  + (PB+2)'(win_reg[5]) + (PB+2)'(win_reg[7]);
        blur_sum  = (PB+4)'(corners) + ((PB+4)'(edges) << 1)
                  + ((PB+4)'(win_reg[4]) << 2);
        sharp_sum = (SW'(win_reg[4]) << 2) + SW'(win_reg[4]) - SW'(edges);
        if (sharpen_mode_reg) begin
            filt_val = sharp_sum[SW-1] ? '0 : sharp_sum;   // negative -> 0
        end else begin
            filt_val = SW'(blur_sum[PB+3:4]);               // divide by 16
        end
        if (GW'(filt_val) > GW'(max_gray_reg)) begin
            filt_pix = max_gray_reg;
        end else begin
            filt_pix = PIX_OUT_W'(filt_val);
        end
    end

    // ------------------------------------------------------------------
    // Result pair for the stage-2 pixel:
    //   res0: row above (border pass-through or filtered interior)
    //   res1: the pixel itself when on the last row
    // ------------------------------------------------------------------
    result_t res0;
    result_t res1;

    always_comb begin
        res0.row      = s2_meta_reg.row - ROW_W'(1);
        res0.last     = !s2_meta_reg.last_row;
        res0.filtered = 1'b0;
        if (s2_meta_reg.c_is0) begin
            res0.pixel = PIX_OUT_W'(win_reg[5]);
            res0.col   = '0;
        end else if (s2_meta_reg.c_is1) begin
            // last column of the row above
            res0.pixel = PIX_OUT_W'(s2_midb_reg);
            res0.col   = s2_meta_reg.wm1_col;
        end else if (s2_meta_reg.r_ge2) begin
            res0.pixel    = filt_pix;
            res0.col      = s2_meta_reg.col - COL_W'(1);
            res0.filtered = 1'b1;
        end else begin
            // top image row passes through
            res0.pixel = PIX_OUT_W'(win_reg[4]);
            res0.col   = s2_meta_reg.col - COL_W'(1);
        end

        res1.pixel    = s2_meta_reg.pix;
        res1.row      = s2_meta_reg.row;
        res1.col      = s2_meta_reg.col;
        res1.filtered = 1'b0;
        res1.last     = 1'b1;
    end

    // ------------------------------------------------------------------
    // Output register plus one pending beat for the second result
    // ------------------------------------------------------------------
    result_t out_reg;
    result_t pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (m_valid_reg && m_ready && pend_valid_reg) begin
            pend_valid_reg <= 1'b0;
        end else if (s2_move && !s2_none) begin
            m_valid_reg    <= 1'b1;
            pend_valid_reg <= s2_meta_reg.r_ge1 && s2_meta_reg.last_row;
        end else if (m_valid_reg && m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && m_ready && pend_valid_reg) begin
            out_reg <= pend_reg;
        end else if (s2_move && !s2_none) begin
            if (s2_meta_reg.r_ge1) begin
                out_reg  <= res0;
                pend_reg <= res1;
            end else begin
                out_reg <= res1;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_out   = out_reg.pixel;
    assign m_out_row     = out_reg.row;
    assign m_out_col     = out_reg.col;
    assign m_is_filtered = out_reg.filtered;
    assign m_last_in_run = out_reg.last;

endmodule

[verif/tb.sv]
// Self-checking testbench for the 3x3 blur/sharpen filter: directed and random pixel streams.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import c3bs_pkg::*;

    localparam int LINE_DEPTH    = 1024;      // line buffer depth, the block's MAX_WIDTH
    localparam int RANDOM_PIXELS = 1450;      // random pixel beats after the directed frames
    localparam int CALM_PIXELS   = 150;       // closing stretch with no idling on either side
    localparam int HOLD_CYCLES   = 300;       // one long receiver hold-off
    localparam int IDLE_PAD      = 12;        // pipe latency plus two buffered pixels, padded
    localparam int RUN_LIMIT_NS  = 4_000_000; // in ns, far above the slowest run

    // Scoreboard: keeps its own copy of the line buffers, window, counters and
    // registers, turns every accepted pixel into the beats it must produce and
    // checks result beats against them in order.
    class blur_scoreboard;
        bit [7:0]       top_line [LINE_DEPTH];
        bit [7:0]       mid_line [LINE_DEPTH];
        bit [7:0]       win [9];
        int             row_cnt;
        int             col_cnt;
        bit [FW_W-1:0]  width_reg;
        bit [FH_W-1:0]  height_reg;
        bit             sharpen;
        bit [MG_W-1:0]  gray_max;
        result_t        expected_beats [$];
        int             mismatches;

        function new();
            row_cnt    = 0;
            col_cnt    = 0;
            width_reg  = 1024;
            height_reg = 1024;
            sharpen    = 1'b0;
            gray_max   = 255;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = data[FW_W-1:0];
                REG_FRAME_HEIGHT: height_reg = data[FH_W-1:0];
                REG_SHARPEN_MODE: sharpen    = data[0];
                REG_MAX_GRAY:     gray_max   = data[MG_W-1:0];
                default: ;
            endcase
        endfunction

        // sizes as the block uses them: saturated to the legal range
        function int eff_width();
            if (width_reg < MIN_SIZE) return MIN_SIZE;
            if (width_reg > LINE_DEPTH) return LINE_DEPTH;
            return width_reg;
        endfunction

        function int eff_height();
            if (height_reg < MIN_SIZE) return MIN_SIZE;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return height_reg;
        endfunction

        function bit frame_start();
            return row_cnt == 0 && col_cnt == 0;
        endfunction

        function int pixels_left();
            int w;
            int h;
            w = eff_width();
            h = eff_height();
            return ((row_cnt >= h - 1) ? 0 : (h - 1 - row_cnt) * w) +
                   ((col_cnt >= w - 1) ? 1 : w - col_cnt);
        endfunction

        // centred 3x3 kernel on the window, clamped to 0..max gray
        function bit [7:0] kernel_value();
            int corners;
            int edges;
            int sum;
            corners = int'(win[0]) + int'(win[2]) + int'(win[6]) + int'(win[8]);
            edges   = int'(win[1]) + int'(win[3]) + int'(win[5]) + int'(win[7]);
            if (sharpen)
                sum = 5 * int'(win[4]) - edges;
            else
                sum = (corners + 2 * edges + 4 * int'(win[4])) / 16;
            if (sum < 0) sum = 0;
            if (sum > int'(gray_max)) sum = gray_max;
            return sum[7:0];
        endfunction

        function result_t beat_of(int pix, int row, int col, bit filt);
            result_t b;
            b.pixel    = pix[PIX_OUT_W-1:0];
            b.row      = row[ROW_W-1:0];
            b.col      = col[COL_W-1:0];
            b.filtered = filt;
            b.last     = 1'b0;
            return b;
        endfunction

        function void note_pixel(bit [7:0] pix);
            int      w;
            int      h;
            int      r;
            int      c;
            int      n;
            bit      last_col;
            bit      last_row;
            result_t res [2];
            w = eff_width();
            h = eff_height();
            r = row_cnt;
            c = col_cnt;
            n = 0;
            last_col = c >= w - 1;
            last_row = r >= h - 1;
            for (int i = 0; i < 3; i++) begin
                win[3*i]   = win[3*i+1];
                win[3*i+1] = win[3*i+2];
            end
            win[2] = top_line[c];
            win[5] = mid_line[c];
            win[8] = pix;
            // line above: column 0 at input column 0, last column at 1, the rest one column behind
            if (r >= 1) begin
                if (c == 0)
                    res[n] = beat_of(mid_line[0], r - 1, 0, 1'b0);
                else if (c == 1)
                    res[n] = beat_of(mid_line[w-1], r - 1, w - 1, 1'b0);
                else if (r >= 2)
                    res[n] = beat_of(kernel_value(), r - 1, c - 1, 1'b1);
                else
                    res[n] = beat_of(win[4], r - 1, c - 1, 1'b0);
                n++;
            end
            top_line[c] = mid_line[c];
            mid_line[c] = pix;
            // bottom line passes straight through as a second beat
            if (last_row) begin
                res[n] = beat_of(pix, r, c, 1'b0);
                n++;
            end
            if (n > 0) res[n-1].last = 1'b1;
            for (int k = 0; k < n; k++) expected_beats.push_back(res[k]);
            if (last_col) begin
                col_cnt = 0;
                row_cnt = last_row ? 0 : (r + 1) & 12'hFFF;
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void check_beat(result_t got);
            result_t want;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat pix=%0d row=%0d col=%0d filt=%0b last=%0b",
                             $time, got.pixel, got.row, got.col, got.filtered, got.last);
                return;
            end
            want = expected_beats.pop_front();
            if (got.pixel !== want.pixel || got.row !== want.row || got.col !== want.col ||
                got.filtered !== want.filtered || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("%0t: beat mismatch exp pix=%0d row=%0d col=%0d filt=%0b last=%0b",
                           $time, want.pixel, want.row, want.col, want.filtered, want.last);
                    $display(" / got pix=%0d row=%0d col=%0d filt=%0b last=%0b",
                             got.pixel, got.row, got.col, got.filtered, got.last);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn    = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [PIX_OUT_W-1:0]  s_pixel_in = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [PIX_OUT_W-1:0]  m_pixel_out;
    logic [ROW_W-1:0]      m_out_row;
    logic [COL_W-1:0]      m_out_col;
    logic                  m_is_filtered;
    logic                  m_last_in_run;

    blur_scoreboard sb;
    int             pixels_sent;
    int             rx_stall_pct;   // chance per cycle that the receiver starts a stall burst
    int             tx_gap_pct;     // chance per pixel that the sender idles after it
    bit             calm;           // closing stretch: no idling anywhere
    bit             hold_req;       // asks the receiver for its long hold-off

    conv3x3_blur_sharpen u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Both channels are sampled at the rising edge, before any register
    // update of that edge lands; stimulus only moves on the falling edge.
    always @(posedge aclk) begin
        result_t seen;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen.pixel    = m_pixel_out;
                seen.row      = m_out_row;
                seen.col      = m_out_col;
                seen.filtered = m_is_filtered;
                seen.last     = m_last_in_run;
                sb.check_beat(seen);
            end
            if (s_valid && s_ready) sb.note_pixel(s_pixel_in);
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, always
    // ready once the run gets calm.
    initial begin : result_sink
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // One pixel beat. Entered on a falling edge; leaves on a falling edge
    // with valid still high unless an idle burst followed, so a following
    // call keeps valid high without a second assignment in the same step.
    task automatic send_pixel(input logic [PIX_OUT_W-1:0] pix);
        int gap;
        s_valid    <= 1'b1;
        s_pixel_in <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        pixels_sent++;
        gap = (!calm && $urandom_range(0, 99) < tx_gap_pct) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Writes the registers flagged in pick (bit i = register index i) back
    // to back; bits above each register's width carry random junk.
    task automatic program_regs(input bit [3:0] pick, input int width_v, input int height_v,
                                input int mode_v, input int gray_v);
        logic [CFG_IDX_W-1:0] ids [4];
        int                   vals [4];
        int                   bits [4];
        ids  = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_SHARPEN_MODE, REG_MAX_GRAY};
        vals = '{width_v, height_v, mode_v, gray_v};
        bits = '{FW_W, FH_W, 1, MG_W};
        for (int i = 0; i < 4; i++) begin
            if (pick[i]) begin
                cfg_valid <= 1'b1;
                cfg_index <= ids[i];
                cfg_data  <= CFG_DATA_W'(($urandom << bits[i]) | (vals[i] & ((1 << bits[i]) - 1)));
                @(posedge aclk);
                while (!cfg_ready) @(posedge aclk);
                sb.write_reg(ids[i], cfg_data);
                @(negedge aclk);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // Sender pause: nothing offered until every expected beat is back, then
    // enough cycles for pixels that give no beat to clear the pipe.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(negedge aclk);
        repeat (IDLE_PAD) @(negedge aclk);
    endtask

    function automatic int pick_gray();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1;
            2, 3:    return $urandom_range(2, 254);
            default: return 255;
        endcase
    endfunction

    initial begin : stimulus
        logic [7:0] board_px [9];
        logic [7:0] spike_px [12];
        int         rnd_start;
        int         left;
        int         chunk;
        int         w_v;
        int         h_v;
        bit         wide_done;
        bit         hold_done;
        sb = new();
        wide_done = 1'b0;
        hold_done = 1'b0;
        rx_stall_pct = 20;
        tx_gap_pct   = 20;
        // checkerboard: blurred centre would be 127
        board_px = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
        // 4x3: the first interior pixel sharpens below zero, the second above 255
        spike_px = '{8'd0,   8'd255, 8'd0,   8'd0,
                     8'd255, 8'd0,   8'd255, 8'd0,
                     8'd0,   8'd255, 8'd0,   8'd0};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // width 0 and height 0 saturate to 3x3; a max gray of zero clamps
        // the filtered centre to 0
        program_regs(4'b1111, 0, 0, 0, 0);
        foreach (board_px[i]) send_pixel(board_px[i]);
        settle();
        // height 2 saturates to 3; sharpen clamps on both sides
        program_regs(4'b1111, 4, 2, 1, 255);
        foreach (spike_px[i]) send_pixel(spike_px[i]);

        rnd_start = pixels_sent;
        while (pixels_sent - rnd_start < RANDOM_PIXELS) begin
            settle();
            calm         = (pixels_sent - rnd_start >= RANDOM_PIXELS - CALM_PIXELS);
            rx_stall_pct = calm ? 0 : 15 * $urandom_range(0, 3);
            tx_gap_pct   = calm ? 0 : 15 * $urandom_range(0, 3);
            if (sb.frame_start()) begin
                if (!wide_done && pixels_sent - rnd_start >= 150) begin
                    // one full line at the widest size: 2047 saturates to 1024
                    // columns, 8191 to 4096 lines; the frame is cut short below
                    wide_done = 1'b1;
                    program_regs(4'b1111, 2047, 8191, $urandom_range(0, 1), 255);
                    chunk = LINE_DEPTH + $urandom_range(3, 20);
                end else begin
                    case ($urandom_range(0, 19))
                        0, 1, 2: w_v = $urandom_range(0, 2);
                        3, 4, 5: w_v = $urandom_range(9, 20);
                        default: w_v = $urandom_range(3, 8);
                    endcase
                    case ($urandom_range(0, 19))
                        0, 1, 2: h_v = $urandom_range(0, 2);
                        3, 4:    h_v = $urandom_range(7, 10);
                        5:       h_v = $urandom_range(4096, 8191);
                        default: h_v = $urandom_range(3, 6);
                    endcase
                    program_regs(4'b1111, w_v, h_v, $urandom_range(0, 1), pick_gray());
                    left = sb.pixels_left();
                    if (!hold_done && pixels_sent - rnd_start >= 300) begin
                        // receiver holds off while the sender keeps offering:
                        // the pipe fills and s_ready has to drop
                        hold_done  = 1'b1;
                        tx_gap_pct = 0;
                        hold_req   = 1'b1;
                        chunk = (left > 40) ? 40 : left;
                    end else if (left > 60) begin
                        chunk = $urandom_range(5, 40);
                    end else begin
                        chunk = ($urandom_range(0, 2) == 0) ? $urandom_range(1, left) : left;
                    end
                end
            end else begin
                // size change within a frame: widths never grow so no line
                // buffer entry is read before it is written; a counter at or
                // past the new last position wraps at the end of that line
                if (sb.eff_height() > 8 || sb.eff_width() > 12) begin
                    program_regs(4'b0011, $urandom_range(0, (sb.eff_width() > 8) ? 8 :
                                 sb.eff_width()), sb.row_cnt + $urandom_range(0, 3), 0, 0);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       program_regs(4'b0001, $urandom_range(0, sb.eff_width()), 0, 0, 0);
                        1:       program_regs(4'b0010, 0, $urandom_range(0, sb.row_cnt + 4), 0, 0);
                        2:       program_regs(4'b0100, 0, 0, !sb.sharpen, 0);
                        default: program_regs(4'b1000, 0, 0, 0, pick_gray());
                    endcase
                end
                left = sb.pixels_left();
                if (left > 60)
                    chunk = $urandom_range(5, 40);
                else
                    chunk = ($urandom_range(0, 2) == 0) ? $urandom_range(1, left) : left;
            end
            // mostly random gray, with the extremes overweighted
            repeat (chunk)
                send_pixel(($urandom_range(0, 7) == 0) ?
                           ($urandom_range(0, 1) ? 8'd255 : 8'd0) : 8'($urandom));
        end

        settle();
        if (sb.mismatches == 0 && sb.expected_beats.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
